// ----- src/vbs_pkg.sv -----
// ----------------------------------------------------------------------------
// vbs_pkg: shared types and constants
// Holds the sequencer state type, operation and register codes, and the
// neighbor offset table used for clamped position shifts.
// ----------------------------------------------------------------------------
package vbs_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_READ,
        S_CALC,
        S_NRD,
        S_NWR
    } t_state;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_SEED  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    localparam logic [2:0] REG_ROWS    = 3'd0;
    localparam logic [2:0] REG_COLS    = 3'd1;
    localparam logic [2:0] REG_SAMPLES = 3'd2;
    localparam logic [2:0] REG_MIN     = 3'd3;
    localparam logic [2:0] REG_RADIUS  = 3'd4;
    localparam logic [2:0] REG_PERSIST = 3'd5;

    localparam logic [1:0] OFFSET_TABLE [9] = '{
        2'b11, 2'b00, 2'b01, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01, 2'b00
    };

    // Shift a position by a table offset and clamp it into [0, lim-1]
    function automatic logic [15:0] shift_pos(input logic [15:0] pos,
                                              input logic [3:0]  choice,
                                              input logic [15:0] lim);
        logic [1:0]         off;
        logic signed [17:0] p;
        logic [15:0]        res;
        off = (choice > 4'd8) ? OFFSET_TABLE[8] : OFFSET_TABLE[choice];
        p   = $signed({2'b00, pos}) + $signed({{16{off[1]}}, off});
        if (p < 0) begin
            res = 16'd0;
        end else if (p >= $signed({2'b00, lim})) begin
            res = lim - 16'd1;
        end else begin
            res = p[15:0];
        end
        return res;
    endfunction

endpackage

// ----- src/vbs_match.sv -----
// ----------------------------------------------------------------------------
// vbs_match: sample match counter
// Compares a pixel against every active packed model sample and decides background.
// ----------------------------------------------------------------------------
module vbs_match #(
    parameter int MAX_SAMPLES = 20
) (
    input  logic [MAX_SAMPLES*8-1:0] i_word,
    input  logic [7:0]               i_pixel,
    input  logic [7:0]               i_radius,
    input  logic [6:0]               i_count,
    input  logic [4:0]               i_min,
    output logic                     o_background
);
    logic [MAX_SAMPLES-1:0] match;
    logic [7:0]             s;
    logic [7:0]             d;

    // Flag each active sample that lies within the radius
    always_comb begin
        match = '0;
        for (int k = 0; k < MAX_SAMPLES; k++) begin
            s = i_word[k*8 +: 8];
            d = (s > i_pixel) ? (s - i_pixel) : (i_pixel - s);
            match[k] = (7'(k) < i_count) && (d < i_radius);
        end
    end

    assign o_background = 32'($countones(match)) >= 32'(i_min);
endmodule

// ----- src/vibe_background_subtractor_top.sv -----
// Sequence: an accepted request passes S_ADDR, S_READ and S_CALC, and the
// result strobe is raised in S_CALC; a new request is taken only in S_IDLE. A
// background test that writes a neighbor sample adds S_NRD and S_NWR for its
// read-modify-write on the sample memory. Reset: synchronous; afterward the
// run-count memory is swept to zero, one pixel per cycle, with busy held high.
// The receiver cannot stall; each result shows for one cycle on o_strobe.
// ----------------------------------------------------------------------------
// vibe_background_subtractor_top: ViBe per-pixel background model
// Sequencer around three memories: packed samples, first frame, run counts.
// ----------------------------------------------------------------------------
module vibe_background_subtractor_top #(
    parameter int MAX_ROWS    = 240,
    parameter int MAX_COLS    = 320,
    parameter int MAX_SAMPLES = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_pixel_row,
    input  logic [8:0] i_pixel_col,
    input  logic [7:0] i_pixel_value,
    input  logic [4:0] i_own_slot,
    input  logic [3:0] i_row_choice,
    input  logic [3:0] i_col_choice,
    input  logic [4:0] i_neighbour_slot,
    input  logic       i_own_gate,
    input  logic       i_neighbour_gate,
    output logic       o_strobe,
    output logic       o_foreground,
    output logic [7:0] o_run_count,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    localparam int NPIX = MAX_ROWS * MAX_COLS;
    localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int SW   = MAX_SAMPLES * 8;

    // configuration
    logic [7:0] r_rows, r_radius, r_persist;
    logic [8:0] r_cols;
    logic [4:0] r_samples, r_min;

    // request
    logic [1:0] r_op;
    logic [7:0] r_row, r_value;
    logic [8:0] r_col;
    logic [4:0] r_own_slot, r_nb_slot;
    logic [3:0] r_row_ch, r_col_ch;
    logic       r_own_gate, r_nb_gate;

    vbs_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_pix, r_nb, r_clr;
    logic            r_inframe;

    logic [SW-1:0] r_smp_q, smp_wd;
    logic [7:0]    r_run_q, r_ff_q, run_wd;
    logic [AW-1:0] smp_ra, smp_wa, run_wa;
    logic          smp_we, run_we, ff_we;

    logic [SW-1:0] smp_mem [NPIX];
    logic [7:0]    ff_mem  [NPIX];
    logic [7:0]    run_mem [NPIX];

    logic [15:0] eff_rows, eff_cols, nr, nc;
    logic [6:0]  eff_smp;
    logic        inframe, bg, own_ok, nb_ok, nb_write;
    logic [7:0]  run_inc;

    // Saturate frame size and sample count at the build maxima
    assign eff_rows = (16'(r_rows) > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : 16'(r_rows);
    assign eff_cols = (16'(r_cols) > 16'(MAX_COLS)) ? 16'(MAX_COLS) : 16'(r_cols);
    assign eff_smp  = (7'(r_samples) > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES)
                                                        : 7'(r_samples);
    assign inframe  = (16'(r_row) < eff_rows) && (16'(r_col) < eff_cols);
    assign nr = vbs_pkg::shift_pos(16'(r_row), r_row_ch, eff_rows);
    assign nc = vbs_pkg::shift_pos(16'(r_col),
                                   (r_op == vbs_pkg::OP_SEED) ? r_row_ch : r_col_ch,
                                   eff_cols);

    vbs_match #(.MAX_SAMPLES(MAX_SAMPLES)) u_match (
        .i_word       (r_smp_q),
        .i_pixel      (r_value),
        .i_radius     (r_radius),
        .i_count      (eff_smp),
        .i_min        (r_min),
        .o_background (bg)
    );

    assign own_ok   = 7'(r_own_slot) < eff_smp;
    assign nb_ok    = 7'(r_nb_slot) < eff_smp;
    assign run_inc  = r_run_q + 8'd1;
    assign nb_write = r_inframe && (r_op == vbs_pkg::OP_TEST) && bg && r_nb_gate && nb_ok;

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 8'd240; r_cols <= 9'd320; r_samples <= 5'd20;
            r_min <= 5'd2; r_radius <= 8'd20; r_persist <= 8'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vbs_pkg::REG_ROWS:    r_rows    <= i_cfg_data[7:0];
                vbs_pkg::REG_COLS:    r_cols    <= i_cfg_data;
                vbs_pkg::REG_SAMPLES: r_samples <= i_cfg_data[4:0];
                vbs_pkg::REG_MIN:     r_min     <= i_cfg_data[4:0];
                vbs_pkg::REG_RADIUS:  r_radius  <= i_cfg_data[7:0];
                vbs_pkg::REG_PERSIST: r_persist <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op <= i_operation; r_row <= i_pixel_row; r_col <= i_pixel_col;
            r_value <= i_pixel_value; r_own_slot <= i_own_slot;
            r_row_ch <= i_row_choice; r_col_ch <= i_col_choice;
            r_nb_slot <= i_neighbour_slot; r_own_gate <= i_own_gate;
            r_nb_gate <= i_neighbour_gate;
        end
    end

    // Form pixel addresses
    always_ff @(posedge i_clk) begin
        if (r_state == vbs_pkg::S_ADDR) begin
            r_inframe <= inframe;
            r_pix <= AW'(32'(r_row) * MAX_COLS + 32'(r_col));
            r_nb  <= AW'(32'(nr[10:0]) * MAX_COLS + 32'(nc[11:0]));
        end
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vbs_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == vbs_pkg::S_CLEAR) r_clr <= r_clr + AW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vbs_pkg::S_CLEAR: if (32'(r_clr) == NPIX - 1) n_state = vbs_pkg::S_IDLE;
            vbs_pkg::S_IDLE:  if (start) n_state = vbs_pkg::S_ADDR;
            vbs_pkg::S_ADDR:  n_state = vbs_pkg::S_READ;
            vbs_pkg::S_READ:  n_state = vbs_pkg::S_CALC;
            vbs_pkg::S_CALC:  n_state = nb_write ? vbs_pkg::S_NRD : vbs_pkg::S_IDLE;
            vbs_pkg::S_NRD:   n_state = vbs_pkg::S_NWR;
            vbs_pkg::S_NWR:   n_state = vbs_pkg::S_IDLE;
            default:          n_state = vbs_pkg::S_IDLE;
        endcase
    end

    // Drive memory writes and the result
    always_comb begin
        busy = (r_state != vbs_pkg::S_IDLE);
        smp_ra = (r_state == vbs_pkg::S_NRD) ? r_nb : r_pix;
        smp_we = 1'b0; smp_wa = r_pix; smp_wd = r_smp_q;
        run_we = 1'b0; run_wa = r_pix; run_wd = 8'd0;
        ff_we  = 1'b0;
        o_strobe = 1'b0; o_foreground = 1'b0; o_run_count = 8'd0;
        unique case (r_state)
            vbs_pkg::S_CLEAR: begin
                run_we = 1'b1; run_wa = r_clr;
            end
            vbs_pkg::S_CALC: begin
                o_strobe = 1'b1;
                if (r_inframe) begin
                    o_run_count = r_run_q;
                    unique case (r_op)
                        vbs_pkg::OP_STORE: ff_we = 1'b1;
                        vbs_pkg::OP_SEED: begin
                            smp_we = own_ok;
                            for (int k = 0; k < MAX_SAMPLES; k++)
                                if (7'(k) == 7'(r_own_slot)) smp_wd[k*8 +: 8] = r_ff_q;
                        end
                        vbs_pkg::OP_TEST: begin
                            run_we = 1'b1;
                            run_wd = bg ? 8'd0 : run_inc;
                            o_foreground = !bg;
                            o_run_count = run_wd;
                            smp_we = r_own_gate && own_ok && (bg || (run_inc > r_persist));
                            for (int k = 0; k < MAX_SAMPLES; k++)
                                if (7'(k) == 7'(r_own_slot)) smp_wd[k*8 +: 8] = r_value;
                        end
                        default: ;
                    endcase
                end
            end
            vbs_pkg::S_NWR: begin
                smp_we = 1'b1; smp_wa = r_nb;
                for (int k = 0; k < MAX_SAMPLES; k++)
                    if (7'(k) == 7'(r_nb_slot)) smp_wd[k*8 +: 8] = r_value;
            end
            default: ;
        endcase
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (smp_we) smp_mem[smp_wa] <= smp_wd;
        r_smp_q <= smp_mem[smp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ff_we) ff_mem[r_pix] <= r_value;
        r_ff_q <= ff_mem[r_nb];
    end

    always_ff @(posedge i_clk) begin
        if (run_we) run_mem[run_wa] <= run_wd;
        r_run_q <= run_mem[r_pix];
    end

    // Checks
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("back-to-back result strobes");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe)) else $error("request not held");
    a_strobe_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == vbs_pkg::S_READ) else $error("strobe out of order");
    a_nb_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vbs_pkg::S_NWR) |-> $past(r_state) == vbs_pkg::S_NRD)
        else $error("neighbor write without read");
endmodule
